// ===== src/csl_pkg.sv =====
// shared types and constants of the c subset lexer
package csl_pkg;

  localparam int unsigned KindW  = 2;
  localparam int unsigned PunctW = 6;
  localparam int unsigned OutW   = 32;

  localparam logic [KindW-1:0] K_IDENT = 2'd0;
  localparam logic [KindW-1:0] K_INT   = 2'd1;
  localparam logic [KindW-1:0] K_PUNCT = 2'd2;
  localparam logic [KindW-1:0] K_EOF   = 2'd3;

  localparam logic [PunctW-1:0] P_NONE  = 6'd63;
  localparam logic [PunctW-1:0] P_ERROR = 6'd45;

  typedef enum logic [4:0] {
    M_IDLE, M_IDENT, M_DEC, M_ZERO, M_OCT, M_HEX,
    M_PLUS, M_MINUS, M_STAR, M_SLASH, M_EQ, M_PCT, M_AMP, M_BAR,
    M_LT, M_LT2, M_GT, M_GT2, M_EXCL, M_CARET,
    M_LINE, M_BLOCK, M_BLOCK_STAR
  } mode_t;

  typedef struct packed {
    logic        eoi;
    logic [7:0]  ch;
    logic        alpha;
    logic        digit;
    logic        octal;
    logic        hexd;
    logic [3:0]  dval;
    logic        ws;
    logic [PunctW-1:0] single;
  } cls_item_t;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [7:0]        ch;
    logic              last;
    logic [PunctW-1:0] punct;
    logic [OutW-1:0]   value;
  } tok_t;

  function automatic logic [PunctW-1:0] single_code(input logic [7:0] c);
    logic [PunctW-1:0] r;
    r = P_NONE;
    case (c)
      8'h5b: r = 6'd0;
      8'h5d: r = 6'd1;
      8'h28: r = 6'd2;
      8'h29: r = 6'd3;
      8'h7b: r = 6'd4;
      8'h7d: r = 6'd5;
      8'h7e: r = 6'd6;
      8'h2c: r = 6'd7;
      8'h2e: r = 6'd8;
      8'h3b: r = 6'd9;
      8'h3f: r = 6'd10;
      8'h3a: r = 6'd11;
      default: r = P_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [PunctW-1:0] lone_code(input mode_t m);
    logic [PunctW-1:0] r;
    r = P_NONE;
    case (m)
      M_PLUS:  r = 6'd14;
      M_MINUS: r = 6'd18;
      M_STAR:  r = 6'd20;
      M_SLASH: r = 6'd22;
      M_EQ:    r = 6'd24;
      M_PCT:   r = 6'd26;
      M_AMP:   r = 6'd29;
      M_BAR:   r = 6'd32;
      M_LT:    r = 6'd36;
      M_LT2:   r = 6'd34;
      M_GT:    r = 6'd40;
      M_GT2:   r = 6'd38;
      M_EXCL:  r = 6'd42;
      M_CARET: r = 6'd44;
      default: r = P_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [PunctW-1:0] pair_code(input mode_t m, input logic [7:0] c);
    logic [PunctW-1:0] r;
    logic eq;
    eq = (c == 8'h3d);
    r  = P_NONE;
    case (m)
      M_PLUS:  r = (c == 8'h2b) ? 6'd12 : eq ? 6'd13 : P_NONE;
      M_MINUS: r = (c == 8'h2d) ? 6'd15 : eq ? 6'd16 : (c == 8'h3e) ? 6'd17 : P_NONE;
      M_STAR:  r = eq ? 6'd19 : P_NONE;
      M_SLASH: r = eq ? 6'd21 : P_NONE;
      M_EQ:    r = eq ? 6'd23 : P_NONE;
      M_PCT:   r = eq ? 6'd25 : P_NONE;
      M_AMP:   r = (c == 8'h26) ? 6'd27 : eq ? 6'd28 : P_NONE;
      M_BAR:   r = (c == 8'h7c) ? 6'd30 : eq ? 6'd31 : P_NONE;
      M_LT:    r = eq ? 6'd35 : P_NONE;
      M_LT2:   r = eq ? 6'd33 : P_NONE;
      M_GT:    r = eq ? 6'd39 : P_NONE;
      M_GT2:   r = eq ? 6'd37 : P_NONE;
      M_EXCL:  r = eq ? 6'd41 : P_NONE;
      M_CARET: r = eq ? 6'd43 : P_NONE;
      default: r = P_NONE;
    endcase
    return r;
  endfunction

  function automatic mode_t op_mode(input logic [7:0] c);
    mode_t r;
    r = M_IDLE;
    case (c)
      8'h2b: r = M_PLUS;
      8'h2d: r = M_MINUS;
      8'h2a: r = M_STAR;
      8'h2f: r = M_SLASH;
      8'h3d: r = M_EQ;
      8'h25: r = M_PCT;
      8'h26: r = M_AMP;
      8'h7c: r = M_BAR;
      8'h3c: r = M_LT;
      8'h3e: r = M_GT;
      8'h21: r = M_EXCL;
      8'h5e: r = M_CARET;
      default: r = M_IDLE;
    endcase
    return r;
  endfunction

endpackage

// ===== src/csl_if.sv =====
// valid/ready channel interfaces of the lexer
interface csl_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_input;
  modport source (output valid, char_code, end_of_input, input ready);
  modport sink (input valid, char_code, end_of_input, output ready);
endinterface

interface csl_tok_if;
  logic        valid;
  logic        ready;
  logic [1:0]  token_kind;
  logic [7:0]  ident_char;
  logic        ident_last;
  logic [5:0]  punct_code;
  logic [31:0] int_value;
  modport source (output valid, token_kind, ident_char, ident_last, punct_code, int_value,
                  input ready);
  modport sink (input valid, token_kind, ident_char, ident_last, punct_code, int_value,
                output ready);
endinterface

// ===== src/csl_front.sv =====
// front part: character classification into a two-entry queue
module csl_front
  import csl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  csl_char_if.sink  in_ch,
  output logic      q_valid,
  input  logic      q_ready,
  output cls_item_t q_item
);

  cls_item_t  mem [2];
  logic       wp, rp;
  logic [1:0] cnt;
  cls_item_t  cur;
  logic [7:0] c;
  logic       push, pop;

  always_comb begin
    c          = in_ch.char_code;
    cur.eoi    = in_ch.end_of_input;
    cur.ch     = c;
    cur.alpha  = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
    cur.digit  = c >= 8'h30 && c <= 8'h39;
    cur.octal  = c >= 8'h30 && c <= 8'h37;
    cur.hexd   = cur.digit || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
    cur.dval   = cur.digit ? c[3:0] : 4'(c[3:0] + 4'd9);
    cur.ws     = c == 8'h20 || c == 8'h09 || c == 8'h0a;
    cur.single = single_code(c);
  end

  assign in_ch.ready = cnt != 2'd2;
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = cnt != 2'd0;
  assign pop         = q_valid && q_ready;
  assign q_item      = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= cur;
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= 2'(cnt + {1'b0, push} - {1'b0, pop});
    end
  end

  assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst) (cnt == 2'd2) |-> !in_ch.ready)
    else $error("full queue accepts");
  assert property (@(posedge clk) disable iff (rst) (push && !pop) |=> cnt != 2'd0)
    else $error("push lost");

endmodule

// ===== src/csl_back.sv =====
// back part: lexer state machine with output register and second-token hold
module csl_back
  import csl_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
)(
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  output logic      q_ready,
  input  cls_item_t q_item,
  csl_tok_if.source out_tok
);

  mode_t                  mode, mode_next;
  logic [7:0]             held, held_next;
  logic [VALUE_WIDTH-1:0] num, num_next;
  tok_t                   t0, t1;
  logic                   n0, n1;
  logic                   ov;
  tok_t                   ot;
  logic                   pv;
  tok_t                   pt;
  logic                   take;
  logic                   flush, restart;
  mode_t                  m;
  logic [PunctW-1:0]      pc;
  logic [VALUE_WIDTH-1:0] mul;

  function automatic tok_t mk(input logic [KindW-1:0] k, input logic [7:0] ch,
                              input logic l, input logic [PunctW-1:0] p,
                              input logic [OutW-1:0] v);
    tok_t r;
    r.kind  = k;
    r.ch    = ch;
    r.last  = l;
    r.punct = p;
    r.value = v;
    return r;
  endfunction

  function automatic logic [OutW-1:0] fit(input logic [VALUE_WIDTH-1:0] v);
    logic [OutW+VALUE_WIDTH-1:0] x;
    x = {{OutW{1'b0}}, v};
    return x[OutW-1:0];
  endfunction

  assign q_ready = !pv && (!ov || out_tok.ready);
  assign take    = q_valid && q_ready;

  always_comb begin
    mode_next = mode;
    held_next = held;
    num_next  = num;
    t0 = mk(K_IDENT, 8'd0, 1'b0, 6'd0, '0);
    t1 = t0;
    n0 = 1'b0;
    n1 = 1'b0;
    flush   = 1'b0;
    restart = 1'b0;
    m   = mode;
    pc  = pair_code(mode, q_item.ch);
    mul = '0;
    if (q_item.eoi) begin
      flush = 1'b1;
    end else begin
      unique case (mode)
        M_IDLE: restart = 1'b1;
        M_IDENT: begin
          if (q_item.alpha || q_item.digit) begin
            n0 = 1'b1;
            t0 = mk(K_IDENT, held, 1'b0, 6'd0, '0);
            held_next = q_item.ch;
          end else begin
            flush = 1'b1; restart = 1'b1;
          end
        end
        M_DEC: begin
          if (q_item.digit) begin
            mul = VALUE_WIDTH'((num << 3) + (num << 1));
            num_next = VALUE_WIDTH'(mul + VALUE_WIDTH'(q_item.dval));
          end else begin
            flush = 1'b1; restart = 1'b1;
          end
        end
        M_ZERO: begin
          if (q_item.ch == 8'h78 || q_item.ch == 8'h58) begin
            mode_next = M_HEX;
          end else if (q_item.octal) begin
            mode_next = M_OCT;
            num_next  = VALUE_WIDTH'(q_item.dval);
          end else begin
            flush = 1'b1; restart = 1'b1;
          end
        end
        M_OCT: begin
          if (q_item.octal) begin
            num_next = VALUE_WIDTH'({num, 3'b000} | VALUE_WIDTH'(q_item.dval));
          end else begin
            flush = 1'b1; restart = 1'b1;
          end
        end
        M_HEX: begin
          if (q_item.hexd) begin
            num_next = VALUE_WIDTH'({num, 4'b0000} | VALUE_WIDTH'(q_item.dval));
          end else begin
            flush = 1'b1; restart = 1'b1;
          end
        end
        M_LINE: if (q_item.ch == 8'h0a) mode_next = M_IDLE;
        M_BLOCK: if (q_item.ch == 8'h2a) mode_next = M_BLOCK_STAR;
        M_BLOCK_STAR: begin
          mode_next = (q_item.ch == 8'h2f) ? M_IDLE :
                      (q_item.ch == 8'h2a) ? M_BLOCK_STAR : M_BLOCK;
        end
        default: begin
          if (mode == M_SLASH && q_item.ch == 8'h2f) mode_next = M_LINE;
          else if (mode == M_SLASH && q_item.ch == 8'h2a) mode_next = M_BLOCK;
          else if (mode == M_LT && q_item.ch == 8'h3c) mode_next = M_LT2;
          else if (mode == M_GT && q_item.ch == 8'h3e) mode_next = M_GT2;
          else if (pc != P_NONE) begin
            mode_next = M_IDLE;
            n0 = 1'b1;
            t0 = mk(K_PUNCT, 8'd0, 1'b0, pc, '0);
          end else begin
            flush = 1'b1; restart = 1'b1;
          end
        end
      endcase
    end
    if (flush) begin
      if (m == M_IDENT) begin
        n0 = 1'b1; t0 = mk(K_IDENT, held, 1'b1, 6'd0, '0);
      end else if (m == M_DEC || m == M_ZERO || m == M_OCT || m == M_HEX) begin
        n0 = 1'b1; t0 = mk(K_INT, 8'd0, 1'b0, 6'd0, fit(num));
      end else if (lone_code(m) != P_NONE) begin
        n0 = 1'b1; t0 = mk(K_PUNCT, 8'd0, 1'b0, lone_code(m), '0);
      end
      mode_next = M_IDLE;
      num_next  = '0;
      if (q_item.eoi) begin
        n1 = 1'b1; t1 = mk(K_EOF, 8'd0, 1'b0, 6'd0, '0);
      end
    end
    if (restart) begin
      if (q_item.ws) begin
      end else if (q_item.alpha) begin
        mode_next = M_IDENT; held_next = q_item.ch;
      end else if (q_item.digit) begin
        mode_next = (q_item.ch == 8'h30) ? M_ZERO : M_DEC;
        num_next  = VALUE_WIDTH'(q_item.dval);
      end else if (q_item.single != P_NONE) begin
        n1 = 1'b1; t1 = mk(K_PUNCT, 8'd0, 1'b0, q_item.single, '0);
      end else if (op_mode(q_item.ch) != M_IDLE) begin
        mode_next = op_mode(q_item.ch);
      end else begin
        n1 = 1'b1; t1 = mk(K_PUNCT, 8'd0, 1'b0, P_ERROR, '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      held <= 8'd0;
      num  <= '0;
      ov   <= 1'b0;
      pv   <= 1'b0;
    end else begin
      if (take) begin
        mode <= mode_next;
        held <= held_next;
        num  <= num_next;
      end
      if (pv && (!ov || out_tok.ready)) begin
        ov <= 1'b1;
        ot <= pt;
        pv <= 1'b0;
      end else if (take && (n0 || n1)) begin
        ov <= 1'b1;
        ot <= n0 ? t0 : t1;
        if (n0 && n1) begin
          pv <= 1'b1;
          pt <= t1;
        end
      end else if (ov && out_tok.ready) begin
        ov <= 1'b0;
      end
    end
  end

  assign out_tok.valid      = ov;
  assign out_tok.token_kind = ot.kind;
  assign out_tok.ident_char = ot.ch;
  assign out_tok.ident_last = ot.last;
  assign out_tok.punct_code = ot.punct;
  assign out_tok.int_value  = ot.value;

  assert property (@(posedge clk) disable iff (rst) pv |-> ov)
    else $error("held token without output");
  assert property (@(posedge clk) disable iff (rst) pv |-> !q_ready)
    else $error("accept while holding second token");
  assert property (@(posedge clk) disable iff (rst)
    (take && q_item.eoi) |=> (mode == M_IDLE))
    else $error("not idle after end of input");

endmodule

// ===== src/c_subset_lexer_unit.sv =====
// top level of the c subset lexer
// a character passes through a queue entry and then the output register before its token leaves
// throughput: one character per cycle while out_tok is ready; a character that yields two tokens
// holds intake until the second token has moved into the output register
// reset: synchronous rst returns the lexer to idle and empties queue and output
module c_subset_lexer_unit
  import csl_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
)(
  input logic       clk,
  input logic       rst,
  csl_char_if.sink  in_ch,
  csl_tok_if.source out_tok
);

  logic      q_valid, q_ready;
  cls_item_t q_item;

  csl_front u_front (
    .clk, .rst, .in_ch, .q_valid, .q_ready, .q_item
  );

  csl_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_item, .out_tok
  );

endmodule
